>>> design/layer_norm_forward_unit_macros.svh
// ----------------------------------------------------------------------------
// Layer norm forward unit assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LAYER_NORM_FORWARD_UNIT_MACROS_SVH
`define LAYER_NORM_FORWARD_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LNF_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LNF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/lnf_pkg.sv
// ----------------------------------------------------------------------------
// Layer norm forward package
// Shared widths, codes, sequencer states and the divider request type.
// ----------------------------------------------------------------------------
package lnf_pkg;

    localparam int MAX_FEATURES_DEF = 64;
    localparam int DATA_W  = 16;
    localparam int CNT_W   = 7;
    localparam int POS_W   = 6;
    localparam int SUM_W   = 23;
    localparam int DEV_W   = 24;
    localparam int SQ_W    = 45;
    localparam int ACC_W   = 51;
    localparam int N2_W    = 14;
    localparam int N3_W    = 19;
    localparam int DVD_W   = 63;
    localparam int DVS_W   = 33;
    localparam int STEP_W  = 7;
    localparam int INV_W   = 32;
    localparam int PROD_W  = 57;
    localparam int MAG_W   = 40;
    localparam int Z_W     = 26;
    localparam int Y_W     = 42;

    localparam logic signed [DATA_W-1:0] SCALE_ONE = 16'sd4096;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic CFG_FEATURE_COUNT = 1'b0;
    localparam logic CFG_EPSILON       = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_N2,
        ST_N3,
        ST_VAR,
        ST_VDIV_GO,
        ST_VDIV_WAIT,
        ST_RDIV_GO,
        ST_RDIV_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_O_RD,
        ST_O_DEV,
        ST_O_MUL,
        ST_O_ZDIV_GO,
        ST_O_ZDIV_WAIT,
        ST_O_SCALE,
        ST_O_RES
    } state_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
        logic [STEP_W-1:0]  steps;
    } div_req_t;

endpackage

>>> design/lnf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lnf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/lnf_div.sv
// ----------------------------------------------------------------------------
// Layer norm iterative divider
// Restoring unsigned division, one quotient bit per cycle, top-aligned dividend.
// ----------------------------------------------------------------------------
module lnf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lnf_pkg::div_req_t           req,
    output logic                        busy,
    output logic [lnf_pkg::DVD_W-1:0]   quotient,
    output logic                        rem_nz
);
    import lnf_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DVD_W-1:0]    quo_reg, quo_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W:0]      shifted;
    logic [DVS_W:0]      diff;

    always_comb begin
        shifted   = {rem_reg, dvd_reg[DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = '0;
            dvd_next  = req.dividend;
            quo_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

endmodule

>>> design/lnf_isqrt.sv
// ----------------------------------------------------------------------------
// Layer norm iterative square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lnf_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lnf_pkg::DVD_W-1:0]   radicand,
    output logic                        busy,
    output logic [lnf_pkg::INV_W-1:0]   root
);
    import lnf_pkg::*;

    logic               busy_reg, busy_next;
    logic [DVD_W-1:0]   x_reg, x_next;
    logic [DVD_W-1:0]   r_reg, r_next;
    logic [DVD_W-1:0]   bit_reg, bit_next;
    logic [DVD_W-1:0]   trial;

    always_comb begin
        trial     = r_reg + bit_reg;
        busy_next = busy_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            x_next    = radicand;
            r_next    = '0;
            // Highest power of four that fits the radicand.
            bit_next  = {1'b1, {(DVD_W-1){1'b0}}};
        end else if (busy_reg) begin
            if (x_reg >= trial) begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = r_reg[INV_W-1:0];

endmodule

>>> design/layer_norm_forward_unit.sv
// ----------------------------------------------------------------------------
// Layer norm forward unit
// Row-wise layer normalisation in fixed point over a buffered row of samples.
// ----------------------------------------------------------------------------
// Items enter on the s_ channel. An item whose tuser is 0 loads the scale and
// shift for one feature position. An item whose tuser is 1 is a sample;
// samples are buffered until the row holds its effective length n of them.
// The last sample starts the row computation, during which s_tready is low:
// a pipelined sum-of-squares pass, a 51-step division by n cubed, a 63-step
// reciprocal division, a 32-step square root, then for each sample a 40-step
// division by n in the shared divider. Results leave on the m_ channel in
// position order, tlast marking the last of the row. A result waits in the
// output register while the receiver stalls; the sequencer holds the next
// result until that register frees. The configuration channel is always
// ready and must only be written while the block is idle; writing
// feature_count drops a partial row. Reset returns every scale to 1.0 and
// every shift to zero through valid bits, clears the row, and sets
// feature_count to 64 and epsilon to 1.
// ----------------------------------------------------------------------------
`include "layer_norm_forward_unit_macros.svh"

module layer_norm_forward_unit #(
    parameter int MAX_FEATURES = lnf_pkg::MAX_FEATURES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: position[5:0], sample[21:6], scale_word[37:22], shift_word[53:38].
    input  logic [55:0] s_tdata,
    // tuser: opcode[0].
    input  logic        s_tuser,
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: normalized[15:0], out_position[21:16].
    output logic [23:0] m_tdata,
    // tlast: row_end.
    output logic        m_tlast,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import lnf_pkg::*;

    localparam int IW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    // Input fields.
    logic                       in_op;
    logic [POS_W-1:0]           in_pos;
    logic signed [DATA_W-1:0]   in_sample;
    logic [DATA_W-1:0]          in_scale;
    logic [DATA_W-1:0]          in_shift;

    assign in_op     = s_tuser;
    assign in_pos    = s_tdata[5:0];
    assign in_sample = s_tdata[21:6];
    assign in_scale  = s_tdata[37:22];
    assign in_shift  = s_tdata[53:38];

    state_t state_reg, state_next;

    // Control state.
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         fc_reg, fc_next;
    logic [DATA_W-1:0]        eps_reg, eps_next;
    logic [MAX_FEATURES-1:0]  pvalid_reg, pvalid_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic                     v0_reg, v1_reg, v2_reg;
    logic                     m_valid_reg, m_valid_next;

    // Datapath registers.
    logic [N2_W-1:0]          n2_reg;
    logic [N3_W-1:0]          n3_reg;
    logic signed [DEV_W-1:0]  d_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [DVS_W-1:0]         v_reg;
    logic [INV_W-1:0]         inv_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [DATA_W-1:0] scl_reg;
    logic signed [DATA_W-1:0] shf_reg;
    logic signed [Y_W-1:0]    y_reg;
    logic [DATA_W-1:0]        m_norm_reg;
    logic [POS_W-1:0]         m_pos_reg;
    logic                     m_last_reg;

    logic [CNT_W-1:0]         n_eff;
    logic                     in_acc;
    logic                     last_sample;
    logic                     is_last;
    logic                     out_load;
    logic                     row_we;
    logic                     par_we;
    logic [IW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] row_rd;
    logic [2*DATA_W-1:0]      par_rd;

    div_req_t                 div_req;
    logic                     div_busy;
    logic [DVD_W-1:0]         div_q;
    logic                     div_rnz;
    logic                     sqrt_start;
    logic                     sqrt_busy;
    logic [INV_W-1:0]         sqrt_root;

    // Effective row length: zero reads as one, anything above the store depth
    // reads as the depth.
    always_comb begin
        if (fc_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (fc_reg > CNT_W'(MAX_FEATURES)) begin
            n_eff = CNT_W'(MAX_FEATURES);
        end else begin
            n_eff = fc_reg;
        end
    end

    assign in_acc      = s_tvalid && s_tready;
    assign last_sample = (fill_reg + 1'b1) >= n_eff;
    assign is_last     = (j_reg == (n_eff - 1'b1));
    assign cfg_ready   = 1'b1;

    // Deviation n*x - S, shared by both passes.
    logic signed [DEV_W-1:0]  nx;
    logic signed [DEV_W:0]    dev_full;
    assign nx       = $signed({1'b0, n_eff}) * row_rd;
    assign dev_full = {nx[DEV_W-1], nx} - {{2{sum_reg[SUM_W-1]}}, sum_reg};

    // Products.
    logic signed [2*DEV_W-1:0] sq_full;
    logic signed [PROD_W-1:0]  p_full;
    logic signed [Y_W-1:0]     y_full;
    assign sq_full = d_reg * d_reg;
    assign p_full  = d_reg * $signed({1'b0, inv_reg});
    assign y_full  = z_reg * scl_reg;

    // Floor division of the product by n * 2^15: shift first, then divide the
    // magnitude and correct a negative quotient downwards.
    logic signed [PROD_W-1:0] p_sh;
    logic [PROD_W-1:0]        p_mag;
    assign p_sh  = p_reg >>> 15;
    assign p_mag = p_sh[PROD_W-1] ? $unsigned(-p_sh) : $unsigned(p_sh);

    logic signed [MAG_W+1:0]  zq;
    logic signed [Z_W-1:0]    z_clamped;
    always_comb begin
        if (p_reg[PROD_W-1]) begin
            zq = -$signed({2'b00, div_q[MAG_W-1:0]}) - $signed({{(MAG_W+1){1'b0}}, div_rnz});
        end else begin
            zq = $signed({2'b00, div_q[MAG_W-1:0]});
        end
        if (zq > $signed((MAG_W+2)'(1) <<< 24)) begin
            z_clamped = Z_W'(1) <<< 24;
        end else if (zq < -$signed((MAG_W+2)'(1) <<< 24)) begin
            z_clamped = -(Z_W'(1) <<< 24);
        end else begin
            z_clamped = zq[Z_W-1:0];
        end
    end

    // Final scaling, offset and saturation.
    logic signed [Y_W-1:0]    y_sh;
    logic signed [22:0]       r_sum;
    logic [DATA_W-1:0]        r_sat;
    assign y_sh  = y_reg >>> 20;
    assign r_sum = $signed(y_sh[21:0]) + 23'(shf_reg);
    always_comb begin
        if (r_sum > 23'sd32767) begin
            r_sat = 16'h7FFF;
        end else if (r_sum < -23'sd32768) begin
            r_sat = 16'h8000;
        end else begin
            r_sat = r_sum[DATA_W-1:0];
        end
    end

    logic [DVS_W:0] v_sum;
    assign v_sum = {1'b0, div_q[DVS_W-1:0]} + {{(DVS_W-DATA_W+1){1'b0}}, eps_reg};

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && in_op == OP_SAMPLE && last_sample) begin
                    state_next = ST_N2;
                end
            end
            ST_N2:        state_next = ST_N3;
            ST_N3:        state_next = ST_VAR;
            ST_VAR: begin
                if (j_reg == n_eff && !v0_reg && !v1_reg && !v2_reg) begin
                    state_next = ST_VDIV_GO;
                end
            end
            ST_VDIV_GO:   state_next = ST_VDIV_WAIT;
            ST_VDIV_WAIT: if (!div_busy) state_next = ST_RDIV_GO;
            ST_RDIV_GO:   state_next = ST_RDIV_WAIT;
            ST_RDIV_WAIT: if (!div_busy) state_next = ST_SQRT_GO;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (!sqrt_busy) state_next = ST_O_RD;
            ST_O_RD:      state_next = ST_O_DEV;
            ST_O_DEV:     state_next = ST_O_MUL;
            ST_O_MUL:     state_next = ST_O_ZDIV_GO;
            ST_O_ZDIV_GO: state_next = ST_O_ZDIV_WAIT;
            ST_O_ZDIV_WAIT: if (!div_busy) state_next = ST_O_SCALE;
            ST_O_SCALE:   state_next = ST_O_RES;
            ST_O_RES: begin
                if (out_load) begin
                    state_next = is_last ? ST_IDLE : ST_O_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready     = 1'b0;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        div_req      = '0;
        rd_addr      = j_reg[IW-1:0];
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_VDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {acc_reg, 12'b0};
                div_req.divisor  = {{(DVS_W-N3_W){1'b0}}, n3_reg};
                div_req.steps    = STEP_W'(ACC_W);
            end
            ST_RDIV_GO: begin
                // Dividend 2^62 for the reciprocal.
                div_req.start    = 1'b1;
                div_req.dividend = {1'b1, {(DVD_W-1){1'b0}}};
                div_req.divisor  = v_reg;
                div_req.steps    = STEP_W'(DVD_W);
            end
            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
            end
            ST_O_ZDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {p_mag[MAG_W-1:0], {(DVD_W-MAG_W){1'b0}}};
                div_req.divisor  = {{(DVS_W-CNT_W){1'b0}}, n_eff};
                div_req.steps    = STEP_W'(MAG_W);
            end
            ST_O_RES: begin
                out_load = !m_valid_reg || m_tready;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Store writes. Load positions at or above the store depth are dropped.
    assign row_we = in_acc && (in_op == OP_SAMPLE);
    assign par_we = in_acc && (in_op == OP_LOAD) && ({1'b0, in_pos} < CNT_W'(MAX_FEATURES));

    lnf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_FEATURES)) u_row_ram (
        .aclk    (aclk),
        .wr_en   (row_we),
        .wr_addr (fill_reg[IW-1:0]),
        .wr_data (in_sample),
        .rd_addr (rd_addr),
        .rd_data (row_rd)
    );

    lnf_ram #(.WIDTH(2*DATA_W), .DEPTH(MAX_FEATURES)) u_par_ram (
        .aclk    (aclk),
        .wr_en   (par_we),
        .wr_addr (in_pos[IW-1:0]),
        .wr_data ({in_scale, in_shift}),
        .rd_addr (rd_addr),
        .rd_data (par_rd)
    );

    lnf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q),
        .rem_nz   (div_rnz)
    );

    lnf_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_q),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // Control next values.
    always_comb begin
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        fc_next      = fc_reg;
        eps_next     = eps_reg;
        pvalid_next  = pvalid_reg;
        j_next       = j_reg;
        m_valid_next = m_valid_reg;

        if (row_we) begin
            fill_next = fill_reg + 1'b1;
            sum_next  = sum_reg + SUM_W'(in_sample);
        end
        if (par_we) begin
            pvalid_next[in_pos[IW-1:0]] = 1'b1;
        end
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FEATURE_COUNT) begin
                fc_next   = cfg_data[CNT_W-1:0];
                fill_next = '0;
                sum_next  = '0;
            end else begin
                eps_next = cfg_data;
            end
        end

        case (state_reg)
            ST_N2:  j_next = '0;
            ST_VAR: if (j_reg != n_eff) j_next = j_reg + 1'b1;
            ST_SQRT_WAIT: j_next = '0;
            ST_O_RES: begin
                if (out_load) begin
                    if (is_last) begin
                        fill_next = '0;
                        sum_next  = '0;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: j_next = j_reg;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            sum_reg     <= '0;
            fc_reg      <= CNT_W'(64);
            eps_reg     <= DATA_W'(1);
            pvalid_reg  <= '0;
            j_reg       <= '0;
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            fc_reg      <= fc_next;
            eps_reg     <= eps_next;
            pvalid_reg  <= pvalid_next;
            j_reg       <= j_next;
            v0_reg      <= (state_reg == ST_VAR) && (j_reg != n_eff);
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers; the sum-of-squares pass is a three-stage pipeline
    // behind the row store read.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_N2: begin
                n2_reg  <= N2_W'(n_eff * n_eff);
                acc_reg <= '0;
            end
            ST_N3: begin
                n3_reg <= N3_W'(n2_reg * n_eff);
            end
            ST_VAR: begin
                if (v0_reg) d_reg <= dev_full[DEV_W-1:0];
                if (v1_reg) sq_reg <= sq_full[SQ_W-1:0];
                if (v2_reg) acc_reg <= acc_reg + ACC_W'(sq_reg);
            end
            ST_VDIV_WAIT: begin
                // Zero variance with zero epsilon is taken as one.
                v_reg <= (v_sum == '0) ? DVS_W'(1) : v_sum[DVS_W-1:0];
            end
            ST_SQRT_WAIT: begin
                inv_reg <= sqrt_root;
            end
            ST_O_DEV: begin
                d_reg   <= dev_full[DEV_W-1:0];
                scl_reg <= pvalid_reg[j_reg[IW-1:0]] ? par_rd[2*DATA_W-1:DATA_W] : SCALE_ONE;
                shf_reg <= pvalid_reg[j_reg[IW-1:0]] ? par_rd[DATA_W-1:0] : '0;
            end
            ST_O_MUL: begin
                p_reg <= p_full;
            end
            ST_O_ZDIV_WAIT: begin
                z_reg <= z_clamped;
            end
            ST_O_SCALE: begin
                y_reg <= y_full;
            end
            default: begin
                n2_reg <= n2_reg;
            end
        endcase
        if (out_load) begin
            m_norm_reg <= r_sat;
            m_pos_reg  <= POS_W'(j_reg);
            m_last_reg <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_pos_reg, m_norm_reg};
    assign m_tlast  = m_last_reg;

    // Checks on the sequencer and the shared units.
    `LNF_ASSERT_NOW(a_tlast_pos, m_tvalid && m_tlast, m_tdata[21:16] == POS_W'(n_eff - 1'b1), "row end at wrong position")
    `LNF_ASSERT_NOW(a_div_free, div_req.start, !div_busy && !sqrt_busy, "divider restarted while busy")
    `LNF_ASSERT_NOW(a_idle_fill, state_reg == ST_IDLE, fill_reg < n_eff, "row fill past its length")
    `LNF_ASSERT_NEXT(a_row_clear, out_load && is_last, fill_reg == '0 && sum_reg == '0, "row not cleared")

endmodule
